>>> rtl/assert_macros.svh
// Assertion helpers shared by the keypad scanner modules.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define KPD_ASSERT_SAME(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("keypad scanner: same-cycle check failed");

// The consequence must hold in the cycle after the condition.
`define KPD_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("keypad scanner: next-cycle check failed");

`endif

>>> rtl/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg
// Types and fixed constants of the keypad scanner with autorepeat FIFO.
// ----------------------------------------------------------------------------
package kpd_pkg;

  // Scancode of key 0; key k sends BASE_CODE + k.
  localparam logic [7:0] BASE_CODE    = 8'h3B;
  // Set in a scancode that reports a release.
  localparam logic [7:0] RELEASE_FLAG = 8'h80;
  // The repeat delay counter stops here.
  localparam logic [7:0] DELAY_MAX    = 8'hFF;
  // Reset value of the first repeat delay register.
  localparam logic [7:0] DELAY_RESET  = 8'd20;

  // Input commands.
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Register index of the first repeat delay register.
  localparam logic REG_FIRST_REPEAT_DELAY = 1'b0;

  // Control sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // One key slot of a scan, offered to the FIFO control.
  typedef struct packed {
    logic       valid;  // this key has a code to push
    logic       last;   // final key slot of the scan
    logic [7:0] code;
  } push_req_t;

endpackage

>>> rtl/kpd_code_ram.sv
// ----------------------------------------------------------------------------
// kpd_code_ram
// Scancode storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kpd_code_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/kpd_key_tracker.sv
// ----------------------------------------------------------------------------
// kpd_key_tracker
// Key mask state, repeat blocking and delay; walks the keys of a scan one
// per cycle and offers each key's scancode.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kpd_key_tracker #(
  parameter int KEY_COUNT = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [KEY_COUNT-1:0]  key_lines,
  input  logic [7:0]            first_repeat_delay,
  output kpd_pkg::push_req_t    push,
  output logic                  scan_active
);

  localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam logic [KW-1:0] LAST_KEY = KW'(KEY_COUNT - 1);

  logic [KEY_COUNT-1:0] prev_keys;
  logic [KEY_COUNT-1:0] blocked;
  logic [7:0]           delay_cnt;
  logic [KEY_COUNT-1:0] emit_mask;
  logic [KEY_COUNT-1:0] rel_mask;
  logic [KW-1:0]        key_idx;
  logic                 busy;

  logic [KEY_COUNT-1:0] fresh;
  logic [KEY_COUNT-1:0] repeat_keys;
  logic [KEY_COUNT-1:0] release_keys;
  logic [KEY_COUNT-1:0] blocked_next;
  logic [7:0]           delay_next;
  logic                 repeat_ok;

  // Classify the keys of the new scan against the previous mask.
  always_comb begin
    fresh        = ~prev_keys & key_lines;
    release_keys = prev_keys & ~key_lines;
    if (fresh == '0) begin
      repeat_keys  = prev_keys & key_lines & ~blocked;
      blocked_next = blocked & ~release_keys;
      delay_next   = (delay_cnt < kpd_pkg::DELAY_MAX) ? delay_cnt + 8'd1 : delay_cnt;
    end else begin
      // A new press blocks every key already held and restarts the delay.
      repeat_keys  = '0;
      blocked_next = prev_keys & key_lines & ~release_keys;
      delay_next   = 8'd1;
    end
    repeat_ok = (delay_next >= first_repeat_delay);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_keys   <= '0;
      blocked     <= '0;
      delay_cnt   <= '0;
      scan_active <= 1'b0;
      busy        <= 1'b0;
      key_idx     <= '0;
    end else if (start) begin
      prev_keys   <= key_lines;
      blocked     <= blocked_next;
      delay_cnt   <= delay_next;
      scan_active <= (key_lines != '0);
      busy        <= 1'b1;
      key_idx     <= '0;
    end else if (busy) begin
      if (key_idx == LAST_KEY) begin
        busy <= 1'b0;
      end else begin
        key_idx <= key_idx + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      emit_mask <= fresh | release_keys | (repeat_ok ? repeat_keys : '0);
      rel_mask  <= release_keys;
    end
  end

  always_comb begin
    push.valid = busy && emit_mask[key_idx];
    push.last  = busy && (key_idx == LAST_KEY);
    push.code  = kpd_pkg::BASE_CODE + 8'(key_idx)
               + (rel_mask[key_idx] ? kpd_pkg::RELEASE_FLAG : 8'h00);
  end

  `KPD_ASSERT_SAME(a_start_when_free, clk, rst, start, !busy)
  `KPD_ASSERT_NEXT(a_start_walks_keys, clk, rst, start, busy && key_idx == '0)

endmodule

>>> rtl/keypad_scancode_autorepeat_top.sv
// ----------------------------------------------------------------------------
// keypad_scancode_autorepeat_top
// Keypad scanner with autorepeat: scan ticks push scancodes into a FIFO
// memory, read requests pop them.
// ----------------------------------------------------------------------------
//
//   Port group   Handshake              Contents
//   input        in_valid / in_ready    cmd, key_lines
//   output       out_valid / out_ready  code, code_valid, fifo_level, any_key_down
//   config       APB psel/penable       first_repeat_delay at byte address 0
//
// A scan tick classifies the keys at its transfer, then walks the keys and
// pushes each key's code into the code memory through its single write port,
// and then loads the result. A read pops the memory at its transfer and
// loads the registered read data into the result. A scan that finds the
// FIFO full and a read of an empty FIFO go straight to the result.
// Reset needs no clearing pass; a stalled result holds the next transfer
// off only once that item has finished and waits for the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keypad_scancode_autorepeat_top #(
  parameter int FIFO_DEPTH = 128,
  parameter int KEY_COUNT  = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  // Item input.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  logic [KEY_COUNT-1:0] key_lines,
  // Result output.
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           code,
  output logic                 code_valid,
  output logic [7:0]           fifo_level,
  output logic                 any_key_down,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(FIFO_DEPTH);
  localparam logic [PW-1:0] LAST_ENTRY = PW'(FIFO_DEPTH - 1);

  kpd_pkg::state_t    state;
  kpd_pkg::state_t    state_next;
  kpd_pkg::push_req_t push;

  logic [7:0]    first_repeat_delay;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [CW-1:0] count;
  logic          popped;
  logic          scan_active;
  logic [7:0]    ram_rd_data;

  logic in_xfer;
  logic fifo_full;
  logic start_scan;
  logic do_pop;
  logic do_push;
  logic out_load;

  // The configuration register is written on the access phase of an APB
  // write. The low two address bits select bytes and are not decoded.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_repeat_delay <= kpd_pkg::DELAY_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == kpd_pkg::REG_FIRST_REPEAT_DELAY) begin
      first_repeat_delay <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == kpd_pkg::REG_FIRST_REPEAT_DELAY)
                ? {24'h0, first_repeat_delay} : 32'h0;

  assign fifo_full = (count == FULL_COUNT);
  assign in_xfer   = in_valid && in_ready;

  // Next state. A scan that finds the FIFO full changes nothing and goes
  // straight to the result, as does every read.
  always_comb begin
    state_next = state;
    unique case (state)
      kpd_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (cmd == kpd_pkg::CMD_SCAN && !fifo_full)
                     ? kpd_pkg::S_SCAN : kpd_pkg::S_DONE;
        end
      end
      kpd_pkg::S_SCAN: begin
        if (push.last) begin
          state_next = kpd_pkg::S_DONE;
        end
      end
      kpd_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = kpd_pkg::S_IDLE;
        end
      end
      default: state_next = kpd_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready   = 1'b0;
    start_scan = 1'b0;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      kpd_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        start_scan = in_valid && cmd == kpd_pkg::CMD_SCAN && !fifo_full;
        do_pop     = in_valid && cmd == kpd_pkg::CMD_READ && count != '0;
      end
      kpd_pkg::S_SCAN: begin
        // Codes that find the FIFO full are dropped; the scan goes on.
        do_push = push.valid && !fifo_full;
      end
      kpd_pkg::S_DONE: begin
        out_load = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= kpd_pkg::S_IDLE;
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
      popped <= 1'b0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        popped <= do_pop;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_ENTRY) ? '0 : rd_ptr + PW'(1);
        count  <= count - CW'(1);
      end else if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_ENTRY) ? '0 : wr_ptr + PW'(1);
        count  <= count + CW'(1);
      end
    end
  end

  // Output register: it frees the input side as soon as a result is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      code         <= popped ? ram_rd_data : 8'h00;
      code_valid   <= popped;
      fifo_level   <= 8'(count);
      any_key_down <= scan_active;
    end
  end

  kpd_code_ram #(
    .DEPTH (FIFO_DEPTH),
    .AW    (PW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (do_push),
    .wr_addr (wr_ptr),
    .wr_data (push.code),
    .rd_en   (do_pop),
    .rd_addr (rd_ptr),
    .rd_data (ram_rd_data)
  );

  kpd_key_tracker #(
    .KEY_COUNT (KEY_COUNT)
  ) u_tracker (
    .clk                (clk),
    .rst                (rst),
    .start              (start_scan),
    .key_lines          (key_lines),
    .first_repeat_delay (first_repeat_delay),
    .push               (push),
    .scan_active        (scan_active)
  );

  `KPD_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= FULL_COUNT)
  `KPD_ASSERT_SAME(a_push_in_scan, clk, rst, do_push, state == kpd_pkg::S_SCAN)
  `KPD_ASSERT_NEXT(a_xfer_leaves_idle, clk, rst, in_xfer, state != kpd_pkg::S_IDLE)
  `KPD_ASSERT_SAME(a_load_after_work, clk, rst, out_load, !in_ready && !do_push)

endmodule

>>> test/keypad_scancode_checker.sv
// ----------------------------------------------------------------------------
// keypad_scancode_checker
// Watches the item, result and configuration channels of the keypad scanner,
// keeps its own copy of the key masks, repeat counter and scancode FIFO, and
// compares every result transfer with the reply that copy predicts.
// ----------------------------------------------------------------------------
module keypad_scancode_checker #(
  parameter int FIFO_DEPTH = 128,
  parameter int KEY_COUNT  = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 cmd,
  input  logic [KEY_COUNT-1:0] key_lines,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [7:0]           code,
  input  logic                 code_valid,
  input  logic [7:0]           fifo_level,
  input  logic                 any_key_down,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  input  logic                 pready,
  input  logic                 final_check,
  output int                   failures
);

  localparam logic [2:0] DELAY_ADDR = {kpd_pkg::REG_FIRST_REPEAT_DELAY, 2'b00};
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] code;
    logic       code_valid;
    logic [7:0] level;
    logic       keys_down;
  } keypad_reply_t;

  // Shadow copy of the scanner state.
  logic [7:0]           code_mem [FIFO_DEPTH];
  int                   rd_idx;
  int                   wr_idx;
  int                   held;
  logic [KEY_COUNT-1:0] last_keys;
  logic [KEY_COUNT-1:0] blocked_keys;
  logic [7:0]           hold_ticks;
  logic                 scanning;
  logic [7:0]           repeat_delay;

  keypad_reply_t        replies[$];
  bit                   final_done;

  // A code that finds the FIFO full is dropped.
  function automatic void push_scancode(logic [7:0] c);
    if (held < FIFO_DEPTH) begin
      code_mem[wr_idx] = c;
      wr_idx = (wr_idx + 1) % FIFO_DEPTH;
      held++;
    end
  endfunction

  function automatic keypad_reply_t advance_keypad(logic c, logic [KEY_COUNT-1:0] lines);
    keypad_reply_t        r;
    logic [KEY_COUNT-1:0] fresh;
    logic [KEY_COUNT-1:0] rpt;
    logic [KEY_COUNT-1:0] rel;
    r = '0;
    if (c == kpd_pkg::CMD_SCAN) begin
      // A scan that starts against a full FIFO changes nothing at all.
      if (held < FIFO_DEPTH) begin
        fresh = ~last_keys & lines;
        rpt   = '0;
        if (fresh == '0) begin
          rpt = last_keys & lines & ~blocked_keys;
        end else begin
          // Keys held across a new press may not repeat until released.
          blocked_keys = last_keys & lines;
          hold_ticks   = '0;
        end
        if (hold_ticks < kpd_pkg::DELAY_MAX) hold_ticks++;
        rel          = last_keys & ~lines;
        blocked_keys = blocked_keys & ~rel;
        for (int k = 0; k < KEY_COUNT; k++) begin
          if (fresh[k]) push_scancode(kpd_pkg::BASE_CODE + 8'(k));
          if (rpt[k] && hold_ticks >= repeat_delay) begin
            push_scancode(kpd_pkg::BASE_CODE + 8'(k));
          end
          if (rel[k]) push_scancode(kpd_pkg::BASE_CODE + 8'(k) + kpd_pkg::RELEASE_FLAG);
        end
        last_keys = lines;
        scanning  = (lines != '0);
      end
    end else if (held > 0) begin
      r.code       = code_mem[rd_idx];
      r.code_valid = 1'b1;
      rd_idx       = (rd_idx + 1) % FIFO_DEPTH;
      held--;
    end
    r.level     = 8'(held);
    r.keys_down = scanning;
    return r;
  endfunction

  always @(posedge clk) begin
    keypad_reply_t want;
    keypad_reply_t got;
    if (rst) begin
      rd_idx       = 0;
      wr_idx       = 0;
      held         = 0;
      last_keys    = '0;
      blocked_keys = '0;
      hold_ticks   = '0;
      scanning     = 1'b0;
      repeat_delay = kpd_pkg::DELAY_RESET;
      failures     = 0;
      final_done   = 1'b0;
      replies.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == DELAY_ADDR) begin
        repeat_delay = pwdata[7:0];
      end
      // Results are matched before the new item is predicted, since no item
      // can produce its result in the cycle of its own transfer.
      if (out_valid && out_ready) begin
        got = '{code, code_valid, fifo_level, any_key_down};
        if (replies.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT) begin
            $display("[%0t] unexpected result: code %02h valid %0d level %0d keys %0d",
                     $realtime, got.code, got.code_valid, got.level, got.keys_down);
          end
        end else begin
          want = replies.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $display("[%0t] result mismatch (expected / actual):", $realtime);
              $display("  code %02h / %02h, code_valid %0d / %0d",
                       want.code, got.code, want.code_valid, got.code_valid);
              $display("  fifo_level %0d / %0d, any_key_down %0d / %0d",
                       want.level, got.level, want.keys_down, got.keys_down);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        replies.push_back(advance_keypad(cmd, key_lines));
      end
      if (final_check && !final_done) begin
        final_done = 1'b1;
        if (replies.size() != 0) begin
          $display("%0d predicted results never arrived", replies.size());
          failures += replies.size();
        end
      end
    end
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives scan ticks and read requests into the keypad scanner, with a short
// directed opening and then random key sequences under several repeat-delay
// settings and handshake pacings; a checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FIFO_DEPTH  = 128;
  localparam int KEY_COUNT   = 6;
  // The slowest correct run stays far below this many cycles.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 125;
  localparam int PHASE_COUNT  = 9;
  localparam logic [2:0] DELAY_ADDR = {kpd_pkg::REG_FIRST_REPEAT_DELAY, 2'b00};

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic                 cmd        = kpd_pkg::CMD_SCAN;
  logic [KEY_COUNT-1:0] key_lines  = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [7:0]           code;
  logic                 code_valid;
  logic [7:0]           fifo_level;
  logic                 any_key_down;
  logic                 psel       = 1'b0;
  logic                 penable    = 1'b0;
  logic                 pwrite     = 1'b0;
  logic [2:0]           paddr      = '0;
  logic [31:0]          pwdata     = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 final_check = 1'b0;
  int                   failures;

  // Pacing of the two channels, in percent of cycles spent idle.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int items_sent    = 0;
  int results_seen  = 0;
  int scans_sent    = 0;
  int reads_sent    = 0;
  int delay_writes  = 0;
  int cycle_count   = 0;

  keypad_scancode_autorepeat_top #(
    .FIFO_DEPTH(FIFO_DEPTH),
    .KEY_COUNT (KEY_COUNT)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .key_lines   (key_lines),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code        (code),
    .code_valid  (code_valid),
    .fifo_level  (fifo_level),
    .any_key_down(any_key_down),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  keypad_scancode_checker #(
    .FIFO_DEPTH(FIFO_DEPTH),
    .KEY_COUNT (KEY_COUNT)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .key_lines   (key_lines),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code        (code),
    .code_valid  (code_valid),
    .fifo_level  (fifo_level),
    .any_key_down(any_key_down),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .final_check (final_check),
    .failures    (failures)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The watchdog ends a run that hangs on a handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d of %0d results seen",
               cycle_count, results_seen, items_sent);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver drops ready at random at the current pacing. It is a
  // registered decision, so it changes only at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every item yields exactly one result, so equal counts mean the block
  // is idle and a register write is safe.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) results_seen <= results_seen + 1;
  end

  function automatic logic [KEY_COUNT-1:0] random_keys();
    return KEY_COUNT'($urandom_range((1 << KEY_COUNT) - 1));
  endfunction

  // Offers one item and returns right after the edge of its transfer. Valid
  // stays high so that a following item is offered without a gap; a random
  // gap lowers it first.
  task automatic send_item(input logic c, input logic [KEY_COUNT-1:0] lines);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    key_lines <= lines;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (c == kpd_pkg::CMD_SCAN) scans_sent++;
    else reads_sent++;
  endtask

  // Waits until every accepted item has delivered its result.
  task automatic settle();
    in_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
  endtask

  // An APB write: setup, then access with penable. The register takes
  // the value at the end of the access phase, since pready is always high.
  task automatic write_delay(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DELAY_ADDR;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    delay_writes++;
  endtask

  // Holds a key mask for a number of scan ticks, with reads mixed in. When
  // allowed, single keys go down or up along the way, which produces new
  // presses while other keys are held and so exercises repeat blocking.
  task automatic hold_keys(input logic [KEY_COUNT-1:0] start_mask, input int len,
                           input int read_pct, input bit may_change);
    logic [KEY_COUNT-1:0] mask;
    int                   bit_idx;
    mask = start_mask;
    for (int i = 0; i < len; i++) begin
      if (may_change && $urandom_range(99) < 12) begin
        bit_idx       = $urandom_range(KEY_COUNT - 1);
        mask[bit_idx] = ~mask[bit_idx];
      end
      send_item(kpd_pkg::CMD_SCAN, mask);
      if ($urandom_range(99) < read_pct) send_item(kpd_pkg::CMD_READ, random_keys());
    end
  endtask

  // One random sequence. Most are well formed key activity; the rest are
  // read bursts that drain (and overdrain) the FIFO and plain noise.
  task automatic run_sequence();
    int                   kind;
    int                   n;
    logic [KEY_COUNT-1:0] mask;
    kind = $urandom_range(99);
    if (kind < 40) begin
      hold_keys(random_keys(), $urandom_range(1, 14), 30, 1'b1);
    end else if (kind < 58) begin
      repeat ($urandom_range(1, 40)) send_item(kpd_pkg::CMD_READ, random_keys());
    end else if (kind < 72) begin
      // Every key flips on every scan, so each scan pushes a full set of
      // codes; without reads the FIFO fills up, fills in mid scan, and then
      // turns whole scans away.
      mask = random_keys();
      n    = $urandom_range(8, 30);
      for (int i = 0; i < n; i++) begin
        send_item(kpd_pkg::CMD_SCAN, (i % 2 == 0) ? mask : ~mask);
      end
    end else begin
      repeat ($urandom_range(1, 10)) begin
        send_item($urandom_range(1) ? kpd_pkg::CMD_READ : kpd_pkg::CMD_SCAN, random_keys());
      end
    end
  endtask

  // The random part goes through thirds of pacing: a mostly eager sender
  // against a slow receiver, the reverse, and then no idling at all.
  task automatic set_pacing(input int phase);
    if (phase < PHASE_COUNT / 3) begin
      send_idle_pct = 7;
      recv_idle_pct = 52;
    end else if (phase < 2 * PHASE_COUNT / 3) begin
      send_idle_pct = 52;
      recv_idle_pct = 7;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  initial begin
    // A negative entry asks for a random delay.
    int   phase_delays[PHASE_COUNT] = '{0, 255, 2, -1, 1, -1, 20, -1, 254};
    int   phase_start;
    logic [7:0] delay_value;

    set_pacing(0);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening, at the reset value of the repeat delay. It reads an
    // empty FIFO, presses and releases every key at once, holds keys below
    // the delay, presses a key while another is held, and releases keys singly
    // and in groups, then reads ten codes back.
    send_item(kpd_pkg::CMD_READ, '1);
    send_item(kpd_pkg::CMD_SCAN, '0);
    send_item(kpd_pkg::CMD_SCAN, '1);
    send_item(kpd_pkg::CMD_READ, '0);
    send_item(kpd_pkg::CMD_READ, '0);
    send_item(kpd_pkg::CMD_SCAN, '1);
    send_item(kpd_pkg::CMD_SCAN, '0);
    send_item(kpd_pkg::CMD_SCAN, KEY_COUNT'(1));
    send_item(kpd_pkg::CMD_SCAN, KEY_COUNT'(3));
    send_item(kpd_pkg::CMD_SCAN, KEY_COUNT'(3));
    send_item(kpd_pkg::CMD_SCAN, KEY_COUNT'(2));
    send_item(kpd_pkg::CMD_SCAN, KEY_COUNT'(32));
    send_item(kpd_pkg::CMD_SCAN, KEY_COUNT'(42));
    send_item(kpd_pkg::CMD_SCAN, KEY_COUNT'(21));
    send_item(kpd_pkg::CMD_SCAN, '0);
    repeat (10) send_item(kpd_pkg::CMD_READ, random_keys());
    settle();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      set_pacing(p);
      delay_value = (phase_delays[p] < 0) ? 8'($urandom_range(255)) : 8'(phase_delays[p]);
      write_delay(delay_value);
      phase_start = items_sent;
      // At the largest delay the counter has to saturate before anything
      // repeats, so one mask is held for more than 255 scans.
      if (delay_value == 8'd255) begin
        hold_keys(KEY_COUNT'($urandom_range(1, (1 << KEY_COUNT) - 1)), 270, 25, 1'b0);
      end
      while (items_sent - phase_start < PHASE_ITEMS) run_sequence();
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    final_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Covered %0d scan ticks and %0d read requests over %0d repeat-delay writes,",
             scans_sent, reads_sent, delay_writes);
    $display("delays 0 and 255 among them, under slow-receiver, slow-sender and free pacing.");
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
